>>> hw/rtl/lcfs_pkg.sv
package lcfs_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int LED_COUNT   = 5;

  localparam int TBL_AW  = $clog2(TABLE_DEPTH);
  localparam int LED_W   = 3;
  localparam int CNT_W   = $clog2(LED_COUNT + 1);
  localparam int POS_W   = $clog2(TABLE_DEPTH + 3 * LED_COUNT + 1);
  localparam int CHAN_W  = 16;
  localparam int STEP_W  = 8;
  localparam int DIV_W   = $clog2(CHAN_W + 1);
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 8;

  localparam logic [STEP_W-1:0] LOOP_FOREVER = 8'hFF;

  // Register indexes of the configuration port
  localparam logic [CFG_IW-1:0] REG_SEQ_LEN   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FADE      = 2'd1;
  localparam logic [CFG_IW-1:0] REG_ALL_SAME  = 2'd2;
  localparam logic [CFG_IW-1:0] REG_LOOPS     = 2'd3;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_e;

  // Channel 0 red, 1 green, 2 blue
  typedef logic [2:0][CHAN_W-1:0] rgb_t;

  typedef struct packed {
    logic shift;
    logic div_start;
    logic div_step;
    logic fade;
    logic snap;
  } cell_ctl_t;

endpackage

>>> hw/rtl/lcfs_ram.sv
module lcfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one word, read one word registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/lcfs_cell.sv
module lcfs_cell import lcfs_pkg::*; (
  input  logic              clk_i,
  input  cell_ctl_t         ctl_i,
  input  logic [STEP_W-1:0] steps_i,
  input  rgb_t              nbr_i,
  output rgb_t              cur_o,
  output rgb_t              tgt_o
);

  rgb_t                   cur_q, tgt_q;
  logic [2:0][CHAN_W-1:0] quo_q;
  logic [2:0][STEP_W-1:0] rem_q;
  logic [2:0]             neg_q;

  logic [2:0][CHAN_W:0]   diff;
  logic [2:0][CHAN_W-1:0] mag;
  logic [2:0][STEP_W:0]   trial;
  logic [2:0]             ge;
  logic [2:0][STEP_W:0]   trial_sub;
  logic [2:0][CHAN_W-1:0] delta;

  // Per channel: difference, magnitude, one division step, signed delta
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c]      = {1'b0, tgt_q[c]} - {1'b0, cur_q[c]};
      mag[c]       = diff[c][CHAN_W] ? (~diff[c][CHAN_W-1:0] + 16'd1) : diff[c][CHAN_W-1:0];
      trial[c]     = {rem_q[c], quo_q[c][CHAN_W-1]};
      ge[c]        = trial[c] >= {1'b0, steps_i};
      trial_sub[c] = trial[c] - {1'b0, steps_i};
      delta[c]     = neg_q[c] ? (~quo_q[c] + 16'd1) : quo_q[c];
    end
  end

  // Shift colours along the chain, or fade toward the target
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      cur_q <= tgt_q;
      tgt_q <= nbr_i;
    end else if (ctl_i.fade) begin
      for (int c = 0; c < 3; c++) begin
        cur_q[c] <= ctl_i.snap ? tgt_q[c] : cur_q[c] + delta[c];
      end
    end
  end

  // Restoring divider, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (ctl_i.div_start) begin
        quo_q[c] <= mag[c];
        rem_q[c] <= '0;
        neg_q[c] <= diff[c][CHAN_W];
      end else if (ctl_i.div_step) begin
        rem_q[c] <= ge[c] ? trial_sub[c][STEP_W-1:0] : trial[c][STEP_W-1:0];
        quo_q[c] <= {quo_q[c][CHAN_W-2:0], ge[c]};
      end
    end
  end

  assign cur_o = cur_q;
  assign tgt_o = tgt_q;

endmodule

>>> hw/rtl/led_color_fade_sequencer_unit.sv
// LED colour fade sequencer: plays a 16-entry colour table on five RGB LEDs, fading
// between key frames. Command words are taken only while the block is idle (in_stall_o
// low). A write, stop or idle tick is handled without leaving idle. A start, and a
// tick that reaches a new key frame, reload the row of five LED cells: six table
// reads through the single RAM read port, then the per-cell bit-serial dividers
// form the fade deltas. A fade tick updates all cells at once. Every tick while
// running then sends five output words, one per cycle when out_stall_i is low;
// the next command word is taken once the fifth word is in the output register.
module led_color_fade_sequencer_unit import lcfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [3:0]        entry_index_i,
  input  logic [CHAN_W-1:0] red_in_i,
  input  logic [CHAN_W-1:0] green_in_i,
  input  logic [CHAN_W-1:0] blue_in_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [LED_W-1:0]  led_index_o,
  output logic [CHAN_W-1:0] red_out_o,
  output logic [CHAN_W-1:0] green_out_o,
  output logic [CHAN_W-1:0] blue_out_o,
  output logic              last_led_o,
  output logic              anim_done_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOAD   = 5'b00010,
    S_LDLAST = 5'b00100,
    S_DIV    = 5'b01000,
    S_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [4:0]        cfg_len_q;
  logic [STEP_W-1:0] cfg_steps_q, cfg_loops_q;
  logic              cfg_same_q;

  logic              run_q, run_d;
  logic              same_q, same_d;
  logic [POS_W-1:0]  pad_q, pad_d, total_q, total_d, frame_q, frame_d;
  logic [STEP_W-1:0] steps_q, steps_d, loops_q, loops_d, fade_q, fade_d;
  logic              done_q, done_d, emit_after_q, emit_after_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [DIV_W-1:0]  cnt_q, cnt_d;
  logic [LED_W-1:0]  led_q, led_d;

  logic              rd_vld_q, zero_q;
  logic [47:0]       rdata;
  rgb_t              entry;

  logic              out_valid_q, out_valid_d, out_load;
  logic [LED_W-1:0]  out_led_q;
  rgb_t              out_rgb_q;
  logic              out_last_q, out_done_q;

  logic              in_acc, cfg_acc;
  cmd_e              cmd;
  cell_ctl_t         ctl;
  rgb_t              cur [LED_COUNT];
  rgb_t              tgt [LED_COUNT];

  logic [POS_W-1:0]  len_sat, pad_new;
  logic [STEP_W:0]   fade_inc;
  logic              frame_adv;
  logic [POS_W-1:0]  frame_inc;
  logic [POS_W-1:0]  pos_sum, pos_mod, rd_off;
  logic              pad_hit;
  logic [LED_W-1:0]  src;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign cmd         = cmd_e'(cmd_i);

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q   <= 5'd1;
      cfg_steps_q <= 8'd1;
      cfg_same_q  <= 1'b0;
      cfg_loops_q <= 8'd0;
    end else if (cfg_acc) begin
      unique case (cfg_index_i)
        REG_SEQ_LEN:  cfg_len_q   <= cfg_data_i[4:0];
        REG_FADE:     cfg_steps_q <= cfg_data_i;
        REG_ALL_SAME: cfg_same_q  <= cfg_data_i[0];
        REG_LOOPS:    cfg_loops_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Colour table
  lcfs_ram #(.Width(48), .Depth(TABLE_DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (in_acc && (cmd == CMD_WRITE)),
    .waddr_i (entry_index_i[TBL_AW-1:0]),
    .wdata_i ({blue_in_i, green_in_i, red_in_i}),
    .raddr_i (rd_off[TBL_AW-1:0]),
    .rdata_o (rdata)
  );

  // Run parameters for a start
  assign len_sat  = ((cfg_len_q == 5'd0) || (POS_W'(cfg_len_q) > POS_W'(TABLE_DEPTH)))
                    ? POS_W'(TABLE_DEPTH) : POS_W'(cfg_len_q);
  assign pad_new  = cfg_same_q ? POS_W'(1) : POS_W'(LED_COUNT);

  // Tick bookkeeping
  assign fade_inc  = {1'b0, fade_q} + 9'd1;
  assign frame_adv = fade_inc >= {1'b0, steps_q};
  assign frame_inc = frame_q + POS_W'(1);

  // Table position for read k of a key frame load
  assign pos_sum = frame_q + POS_W'(k_q);
  assign pos_mod = (pos_sum >= total_q) ? pos_sum - total_q : pos_sum;
  assign pad_hit = (pos_mod < pad_q) || (pos_mod >= total_q - pad_q);
  assign rd_off  = pos_mod - pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == S_LOAD);
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= pad_hit;
  end

  assign entry = zero_q ? '0 : rgb_t'(rdata);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    run_d        = run_q;
    same_d       = same_q;
    pad_d        = pad_q;
    total_d      = total_q;
    frame_d      = frame_q;
    steps_d      = steps_q;
    loops_d      = loops_q;
    fade_d       = fade_q;
    done_d       = done_q;
    emit_after_d = emit_after_q;
    k_d          = k_q;
    cnt_d        = cnt_q;
    led_d        = led_q;
    ctl          = '0;
    ctl.shift    = rd_vld_q;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            CMD_WRITE: ;
            CMD_START: begin
              run_d        = 1'b1;
              same_d       = cfg_same_q;
              pad_d        = pad_new;
              total_d      = len_sat + (pad_new << 1);
              steps_d      = (cfg_steps_q == 8'd0) ? 8'd1 : cfg_steps_q;
              loops_d      = cfg_loops_q;
              frame_d      = '0;
              fade_d       = '0;
              emit_after_d = 1'b0;
              done_d       = 1'b0;
              k_d          = '0;
              state_d      = S_LOAD;
            end
            CMD_STOP: run_d = 1'b0;
            CMD_TICK: begin
              if (run_q) begin
                done_d = 1'b0;
                if (frame_adv) begin
                  fade_d       = '0;
                  frame_d      = frame_inc;
                  emit_after_d = 1'b1;
                  k_d          = '0;
                  state_d      = S_LOAD;
                  if (frame_inc == total_q - pad_q) begin
                    if (loops_q != 8'd0) begin
                      if (loops_q != LOOP_FOREVER) begin
                        loops_d = loops_q - 8'd1;
                      end
                      frame_d = '0;
                    end else begin
                      done_d  = 1'b1;
                      run_d   = 1'b0;
                      led_d   = '0;
                      state_d = S_EMIT;
                    end
                  end
                end else begin
                  fade_d   = fade_inc[STEP_W-1:0];
                  ctl.fade = 1'b1;
                  ctl.snap = (fade_inc[STEP_W-1:0] == steps_q - 8'd1);
                  led_d    = '0;
                  state_d  = S_EMIT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        k_d = k_q + CNT_W'(1);
        if (k_q == CNT_W'(LED_COUNT)) begin
          k_d     = '0;
          state_d = S_LDLAST;
        end
      end
      S_LDLAST: begin
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        ctl.div_start = (cnt_q == '0);
        ctl.div_step  = (cnt_q != '0);
        cnt_d         = cnt_q + DIV_W'(1);
        if (cnt_q == DIV_W'(CHAN_W)) begin
          led_d   = '0;
          state_d = emit_after_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          led_d    = led_q + LED_W'(1);
          if (led_q == LED_W'(LED_COUNT - 1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      run_q        <= 1'b0;
      same_q       <= 1'b0;
      pad_q        <= POS_W'(1);
      total_q      <= POS_W'(3);
      frame_q      <= '0;
      steps_q      <= 8'd1;
      loops_q      <= '0;
      fade_q       <= '0;
      done_q       <= 1'b0;
      emit_after_q <= 1'b0;
      k_q          <= '0;
      cnt_q        <= '0;
      led_q        <= '0;
    end else begin
      state_q      <= state_d;
      run_q        <= run_d;
      same_q       <= same_d;
      pad_q        <= pad_d;
      total_q      <= total_d;
      frame_q      <= frame_d;
      steps_q      <= steps_d;
      loops_q      <= loops_d;
      fade_q       <= fade_d;
      done_q       <= done_d;
      emit_after_q <= emit_after_d;
      k_q          <= k_d;
      cnt_q        <= cnt_d;
      led_q        <= led_d;
    end
  end

  // Row of LED cells; table words enter at the last cell
  for (genvar i = 0; i < LED_COUNT; i++) begin : g_cell
    rgb_t nbr;
    if (i == LED_COUNT - 1) begin : g_end
      assign nbr = entry;
    end else begin : g_mid
      assign nbr = tgt[i+1];
    end
    lcfs_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .steps_i (steps_q),
      .nbr_i   (nbr),
      .cur_o   (cur[i]),
      .tgt_o   (tgt[i])
    );
  end

  // Output register
  assign src         = same_q ? '0 : led_q;
  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_led_q  <= led_q;
      out_rgb_q  <= done_q ? '0 : cur[src];
      out_last_q <= (led_q == LED_W'(LED_COUNT - 1));
      out_done_q <= done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_index_o = out_led_q;
  assign red_out_o   = out_rgb_q[0];
  assign green_out_o = out_rgb_q[1];
  assign blue_out_o  = out_rgb_q[2];
  assign last_led_o  = out_last_q;
  assign anim_done_o = out_done_q;

endmodule

>>> hw/rtl/lcfs_checker.sv
module lcfs_checker import lcfs_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [LED_W-1:0]  led_index_o,
  input logic [CHAN_W-1:0] red_out_o,
  input logic [CHAN_W-1:0] green_out_o,
  input logic [CHAN_W-1:0] blue_out_o,
  input logic              last_led_o,
  input logic              anim_done_o
);

  // A stalled word stays valid, with its LED index and red value held
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(led_index_o) && $stable(red_out_o))
    else $error("stalled output word changed");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_led_o == (led_index_o == LED_W'(LED_COUNT - 1))))
    else $error("last_led does not match led index");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && anim_done_o |-> (red_out_o == '0) && (green_out_o == '0)
                                   && (blue_out_o == '0))
    else $error("finishing word carries colour");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (led_index_o < LED_W'(LED_COUNT)))
    else $error("led index out of range");

endmodule

bind led_color_fade_sequencer_unit lcfs_checker u_lcfs_checker (.*);

>>> dv/led_color_fade_sequencer_unit_tb.sv
module led_color_fade_sequencer_unit_tb;
  import lcfs_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int HOLD_CYCLES    = 400;

  typedef enum logic [1:0] {PLAY_IDLE, PLAY_SAME, PLAY_SHIFT} play_e;

  typedef struct packed {
    logic [LED_W-1:0]  led;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
    logic              done;
  } led_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        cmd_i = '0;
  logic [3:0]        entry_index_i = '0;
  logic [CHAN_W-1:0] red_in_i = '0;
  logic [CHAN_W-1:0] green_in_i = '0;
  logic [CHAN_W-1:0] blue_in_i = '0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b1;
  logic [LED_W-1:0]  led_index_o;
  logic [CHAN_W-1:0] red_out_o;
  logic [CHAN_W-1:0] green_out_o;
  logic [CHAN_W-1:0] blue_out_o;
  logic              last_led_o;
  logic              anim_done_o;

  led_color_fade_sequencer_unit u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the sequencer state
  logic [CHAN_W-1:0] tbl [TABLE_DEPTH][3];
  logic [CHAN_W-1:0] cur [LED_COUNT][3];
  logic [CHAN_W-1:0] tgt [LED_COUNT][3];
  int                dlt [LED_COUNT][3];
  play_e             mode = PLAY_IDLE;
  int unsigned       frame_pos, fade_pos, loops_left;
  int unsigned       seq_len = 1, fade_cfg = 1, same_cfg = 0, loop_cfg = 0;
  int unsigned       run_total = 3, run_pad = 1, run_steps = 1;

  led_word_t   led_words_q[$];
  int          err_cnt = 0;
  int          sent_cnt = 0;
  int          word_cnt = 0;
  int          done_cnt = 0;
  int          idle_cycles = 0;
  bit          hold_req = 0;
  bit          quiet = 0;

  function automatic void stage(input int unsigned pos, output logic [CHAN_W-1:0] dst [3]);
    for (int c = 0; c < 3; c++)
      dst[c] = (pos < run_pad || pos >= run_total - run_pad) ? '0 : tbl[pos - run_pad][c];
  endfunction

  function automatic void load_frame();
    int unsigned n;
    n = (mode == PLAY_SAME) ? 1 : LED_COUNT;
    for (int i = 0; i < n; i++) begin
      stage((frame_pos + i) % run_total, cur[i]);
      stage((frame_pos + i + 1) % run_total, tgt[i]);
      // truncate toward zero, as signed integer division does
      for (int c = 0; c < 3; c++)
        dlt[i][c] = (int'(tgt[i][c]) - int'(cur[i][c])) / int'(run_steps);
    end
  endfunction

  function automatic void push_leds(input bit done);
    led_word_t w;
    int src;
    for (int i = 0; i < LED_COUNT; i++) begin
      src = (mode == PLAY_SAME) ? 0 : i;
      w.led   = LED_W'(i);
      w.red   = done ? '0 : cur[src][0];
      w.green = done ? '0 : cur[src][1];
      w.blue  = done ? '0 : cur[src][2];
      w.last  = (i == LED_COUNT - 1);
      w.done  = done;
      led_words_q.push_back(w);
    end
  endfunction

  function automatic void predict_cmd(input cmd_e cmd, input logic [3:0] idx,
                                      input logic [CHAN_W-1:0] r, g, b);
    int unsigned n;
    case (cmd)
      CMD_WRITE: begin
        tbl[idx][0] = r; tbl[idx][1] = g; tbl[idx][2] = b;
      end
      CMD_START: begin
        n = (seq_len == 0 || seq_len > TABLE_DEPTH) ? TABLE_DEPTH : seq_len;
        mode       = same_cfg ? PLAY_SAME : PLAY_SHIFT;
        run_pad    = same_cfg ? 1 : LED_COUNT;
        run_total  = n + 2 * run_pad;
        run_steps  = fade_cfg ? fade_cfg : 1;
        loops_left = loop_cfg;
        frame_pos  = 0;
        fade_pos   = 0;
        load_frame();
      end
      CMD_STOP: mode = PLAY_IDLE;
      default: begin
        if (mode == PLAY_IDLE) return;
        fade_pos = (fade_pos + 1) & 8'hFF;
        if (fade_pos >= run_steps) begin
          fade_pos = 0;
          frame_pos++;
          if (frame_pos == run_total - run_pad) begin
            if (loops_left != 0) begin
              if (loops_left != LOOP_FOREVER) loops_left--;
              frame_pos = 0;
            end else begin
              push_leds(1'b1);
              mode = PLAY_IDLE;
              return;
            end
          end
          load_frame();
        end else begin
          n = (mode == PLAY_SAME) ? 1 : LED_COUNT;
          for (int i = 0; i < n; i++)
            for (int c = 0; c < 3; c++)
              cur[i][c] = (fade_pos == run_steps - 1) ? tgt[i][c]
                                                      : cur[i][c] + CHAN_W'(dlt[i][c]);
        end
        push_leds(1'b0);
      end
    endcase
  endfunction

  // Check each output word against the oldest expectation
  always @(posedge clk_i) begin
    led_word_t e;
    if (out_valid_o && !out_stall_i) begin
      word_cnt++;
      if (led_words_q.size() == 0) begin
        $error("unexpected output word led_index=%0d", led_index_o);
        err_cnt++;
      end else begin
        e = led_words_q.pop_front();
        if (e.done) done_cnt++;
        if (led_index_o !== e.led) begin
          $error("led_index exp %0d got %0d", e.led, led_index_o); err_cnt++;
        end
        if (red_out_o !== e.red) begin
          $error("red_out exp %h got %h", e.red, red_out_o); err_cnt++;
        end
        if (green_out_o !== e.green) begin
          $error("green_out exp %h got %h", e.green, green_out_o); err_cnt++;
        end
        if (blue_out_o !== e.blue) begin
          $error("blue_out exp %h got %h", e.blue, blue_out_o); err_cnt++;
        end
        if (last_led_o !== e.last) begin
          $error("last_led exp %0b got %0b", e.last, last_led_o); err_cnt++;
        end
        if (anim_done_o !== e.done) begin
          $error("anim_done exp %0b got %0b", e.done, anim_done_o); err_cnt++;
        end
      end
    end
  end

  // Drive output stall: random gaps, quiet stretches, one long hold-off on request
  always @(posedge clk_i) begin
    int stall_left;
    if (!rst_ni) begin
      stall_left = 0;
    end else if (hold_req) begin
      hold_req = 0;
      stall_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:64]:  out_stall_i <= 1'b0;
        [65:94]: out_stall_i <= 1'b1;
        default: begin
          stall_left = $urandom_range(10, 40);
          out_stall_i <= 1'b1;
        end
      endcase
    end
  end

  // Count cycles in which no word moves on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d words pending", led_words_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_cmd(input cmd_e cmd, input logic [3:0] idx = '0,
                          input logic [CHAN_W-1:0] r = '0, g = '0, b = '0);
    int gap;
    case ($urandom_range(0, 99)) inside
      [0:54]:  gap = 0;
      [55:91]: gap = $urandom_range(1, 3);
      default: gap = $urandom_range(10, 40);
    endcase
    if (quiet) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    entry_index_i <= idx;
    red_in_i      <= r;
    green_in_i    <= g;
    blue_in_i     <= b;
    do @(posedge clk_i); while (in_stall_o);
    predict_cmd(cmd, idx, r, g, b);
    sent_cnt++;
  endtask

  task automatic send_tick();
    send_cmd(CMD_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_write(input logic [3:0] idx);
    send_cmd(CMD_WRITE, idx, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Drop valid, then let every expected word arrive and the block go quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (led_words_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers back to back; call only after drain
  task automatic set_config(input int unsigned len, fade, same, loops);
    logic [CFG_DW-1:0] vals [4];
    vals = '{CFG_DW'(len), CFG_DW'(fade), CFG_DW'(same), CFG_DW'(loops)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_IW'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (CFG_IW'(i))
        REG_SEQ_LEN:  seq_len  = vals[i] & 5'h1F;
        REG_FADE:     fade_cfg = vals[i];
        REG_ALL_SAME: same_cfg = vals[i] & 1'b1;
        REG_LOOPS:    loop_cfg = vals[i];
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Fill every table entry, extremes first, and poke the idle commands
  task automatic test_table_fill();
    send_cmd(CMD_WRITE, 4'd0, 16'h0000, 16'hFFFF, 16'h0000);
    send_cmd(CMD_WRITE, 4'd15, 16'hFFFF, 16'h0000, 16'hFFFF);
    for (int i = 1; i < TABLE_DEPTH - 1; i++) send_write(4'(i));
    send_tick();
    send_cmd(CMD_STOP);
    drain();
  endtask

  // Short runs: shift mode to completion with one loop, saturated same mode forever
  task automatic test_directed_runs();
    set_config(1, 1, 0, 1);
    send_cmd(CMD_START);
    repeat (13) send_tick();
    drain();
    set_config(31, 0, 1, 255);
    send_cmd(CMD_START);
    repeat (4) send_tick();
    send_cmd(CMD_STOP);
    send_tick();
    drain();
    set_config(0, 255, 0, 0);
    send_cmd(CMD_START);
    repeat (3) send_tick();
    send_cmd(CMD_STOP);
    drain();
  endtask

  // Random settings, mostly ticking runs with writes, restarts and stops mixed in
  task automatic test_random_runs();
    int unsigned len, fade, loops, burst;
    while (sent_cnt < 180) begin
      case ($urandom_range(0, 5))
        0:       len = $urandom_range(0, 31);
        5:       len = 16;
        default: len = $urandom_range(1, 3);
      endcase
      case ($urandom_range(0, 7))
        0:       fade = $urandom_range(0, 255);
        1:       fade = 255;
        default: fade = $urandom_range(1, 3);
      endcase
      loops = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 1);
      if ($urandom_range(0, 9) == 0) loops = $urandom_range(0, 255);
      set_config(len, fade, $urandom_range(0, 1), loops);
      quiet = ($urandom_range(0, 3) == 0);
      send_cmd(CMD_START);
      burst = $urandom_range(10, 30);
      repeat (burst) begin
        case ($urandom_range(0, 39)) inside
          [0:33]:  send_tick();
          [34:36]: send_write(4'($urandom));
          37:      send_cmd(CMD_START);
          default: send_cmd(CMD_STOP);
        endcase
      end
      quiet = 0;
      drain();
    end
  endtask

  // Hold the receiver off while ticks keep coming so the input backs up
  task automatic test_backpressure();
    set_config(4, 2, 0, 255);
    send_cmd(CMD_START);
    hold_req = 1;
    repeat (15) send_tick();
    send_cmd(CMD_STOP);
    drain();
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++)
      for (int c = 0; c < 3; c++) tbl[i][c] = '0;
    for (int i = 0; i < LED_COUNT; i++)
      for (int c = 0; c < 3; c++) begin
        cur[i][c] = '0; tgt[i][c] = '0; dlt[i][c] = 0;
      end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_table_fill();
    test_directed_runs();
    test_backpressure();
    test_random_runs();
    drain();
    $display("covered %0d command words, %0d LED words, %0d finished animations",
             sent_cnt, word_cnt, done_cnt / LED_COUNT);
    $display("runs mixed shift and same modes, loops, restarts and a long output hold-off");
    if (err_cnt == 0 && led_words_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
